// File: src/ght_pkg.sv
`default_nettype none
package ght_pkg;

	localparam int GHT_SLOTS         = 4096;
	localparam int GHT_REFCOUNT_BITS = 24;

	localparam logic [3:0] K_RESERVE   = 4'd0;
	localparam logic [3:0] K_ALLOC     = 4'd1;
	localparam logic [3:0] K_BIND      = 4'd2;
	localparam logic [3:0] K_FREE      = 4'd3;
	localparam logic [3:0] K_RELEASE   = 4'd4;
	localparam logic [3:0] K_LOOKUP    = 4'd5;
	localparam logic [3:0] K_ADDREF    = 4'd6;
	localparam logic [3:0] K_RELREF    = 4'd7;
	localparam logic [3:0] K_SET_ROOT  = 4'd8;
	localparam logic [3:0] K_CLR_ROOT  = 4'd9;
	localparam logic [3:0] K_SET_PEND  = 4'd10;
	localparam logic [3:0] K_CLR_PEND  = 4'd11;
	localparam logic [3:0] K_SET_GARB  = 4'd12;
	localparam logic [3:0] K_READ      = 4'd13;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_REJECT   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_OVF      = 2'd3;

	localparam logic [3:0] FLAG_ROOT    = 4'd1;
	localparam logic [3:0] FLAG_PENDING = 4'd2;
	localparam logic [3:0] FLAG_GARBAGE = 4'd4;

	typedef struct packed {
		logic [1:0] status;
		logic       changed;
		logic       push;
		logic       live_inc;
		logic       live_dec;
	} mod_info_t;

endpackage
`default_nettype wire

// File: src/ght_modify.sv
`default_nettype none
module ght_modify import ght_pkg::*; #(
	parameter int REFCOUNT_BITS = GHT_REFCOUNT_BITS
) (
	input  wire logic [3:0]               kind,
	input  wire logic                     fresh,
	input  wire logic                     stk_full,
	input  wire logic [31:0]              obj_in,
	input  wire logic [31:0]              exp_serial,
	input  wire logic [31:0]              old_serial,
	input  wire logic [31:0]              old_object,
	input  wire logic [REFCOUNT_BITS-1:0] old_refc,
	input  wire logic [3:0]               old_flags,
	output logic [31:0]                   new_serial,
	output logic [31:0]                   new_object,
	output logic [REFCOUNT_BITS-1:0]      new_refc,
	output logic [3:0]                    new_flags,
	output logic [31:0]                   res_object,
	output mod_info_t                     info
);

	logic        set_obj;
	logic [31:0] obj_val;
	logic [31:0] ser_inc;
	logic [3:0]  mask;
	logic        setting;

	always_comb begin
		new_serial = fresh ? 32'd1 : old_serial;
		new_object = old_object;
		new_refc   = old_refc;
		new_flags  = old_flags;
		info       = '0;
		set_obj    = 1'b0;
		obj_val    = '0;
		mask       = '0;
		setting    = 1'b0;
		ser_inc    = old_serial + 32'd1;
		case (kind) inside
			K_RESERVE, K_ALLOC: begin
				set_obj = 1'b1;
				obj_val = (kind == K_ALLOC) ? obj_in : 32'd0;
			end
			K_BIND: begin
				if (obj_in == 32'd0) begin
					info.status = ST_REJECT;
				end else begin
					set_obj = 1'b1;
					obj_val = obj_in;
				end
			end
			K_FREE, K_RELEASE: begin
				new_serial = (ser_inc == 32'd0) ? 32'd1 : ser_inc;
				set_obj    = 1'b1;
				if (kind == K_RELEASE)
					new_flags = '0;
				if (stk_full)
					info.status = ST_OVF;
				else
					info.push = 1'b1;
			end
			K_ADDREF: begin
				if (old_refc != {REFCOUNT_BITS{1'b1}})
					new_refc = old_refc + 1'b1;
			end
			K_RELREF: begin
				if (old_refc != '0)
					new_refc = old_refc - 1'b1;
			end
			K_SET_ROOT: begin mask = FLAG_ROOT; setting = 1'b1; end
			K_CLR_ROOT: mask = FLAG_ROOT;
			K_SET_PEND: begin mask = FLAG_PENDING; setting = 1'b1; end
			K_CLR_PEND: mask = FLAG_PENDING;
			K_SET_GARB: begin mask = FLAG_GARBAGE; setting = 1'b1; end
			default: ;
		endcase
		if (mask != '0) begin
			new_flags    = setting ? (old_flags | mask) : (old_flags & ~mask);
			info.changed = (new_flags != old_flags);
		end
		if (set_obj) begin
			info.live_inc = (old_object == 32'd0) && (obj_val != 32'd0);
			info.live_dec = (old_object != 32'd0) && (obj_val == 32'd0);
			new_object    = obj_val;
		end
		res_object = (kind == K_LOOKUP && new_serial != exp_serial) ? 32'd0 : new_object;
	end

endmodule
`default_nettype wire

// File: src/generational_handle_table_top.sv
`default_nettype none
// channel | signals                    | word
// in      | in_valid / in_ready        | kind, slot_index, expected_serial, object_ref
// out     | out_valid / out_ready      | status, result_slot, result_serial, result_object,
//         |                            | result_refcount, result_flags, changed, live_count
// An operation passes through accept and entry read-modify-write; when a slot is
// popped off the free stack, the stack read precedes the entry read.
// After reset a clearing pass zeroes the entry memory, with in_ready low.
// The result register lets a new word in while a result waits; the modify step
// stalls only when the previous result is still untaken.
module generational_handle_table_top import ght_pkg::*; #(
	parameter int SLOTS         = GHT_SLOTS,
	parameter int REFCOUNT_BITS = GHT_REFCOUNT_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [3:0]                   kind,
	input  wire logic [$clog2(SLOTS)-1:0]     slot_index,
	input  wire logic [31:0]                  expected_serial,
	input  wire logic [31:0]                  object_ref,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [1:0]                        status,
	output logic [$clog2(SLOTS)-1:0]          result_slot,
	output logic [31:0]                       result_serial,
	output logic [31:0]                       result_object,
	output logic [REFCOUNT_BITS-1:0]          result_refcount,
	output logic [3:0]                        result_flags,
	output logic                              changed,
	output logic [$clog2(SLOTS+1)-1:0]        live_count
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS+1);
	localparam int RB = REFCOUNT_BITS;
	localparam int EW = 68 + RB;

	localparam logic [1:0] S_CLR  = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;
	localparam logic [1:0] S_MOD  = 2'd3;

	logic [EW-1:0] ent_mem [SLOTS];
	logic [IW-1:0] stk_mem [SLOTS];
	logic [EW-1:0] ent_rd_q;
	logic [IW-1:0] stk_rd_q;

	logic [1:0]    st_q;
	logic [IW-1:0] clr_q;
	logic [CW-1:0] fsc_q;
	logic [CW-1:0] bump_q;
	logic [CW-1:0] live_q;

	logic [3:0]    kind_q;
	logic [IW-1:0] slot_q;
	logic [31:0]   exp_q;
	logic [31:0]   obj_q;
	logic          fresh_q;
	logic          rej_q;
	logic [1:0]    rej_st_q;

	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [IW-1:0] slot_out_q;
	logic [31:0]   serial_q;
	logic [31:0]   object_q;
	logic [RB-1:0] refc_q;
	logic [3:0]    flags_q;
	logic          changed_q;
	logic [CW-1:0] live_out_q;

	logic          accept;
	logic          fire;
	logic          take;
	logic          idx_bad;
	logic          ent_we, ent_re, stk_we, stk_re;
	logic [IW-1:0] ent_wa, ent_ra;
	logic [EW-1:0] ent_wd;
	logic [CW-1:0] live_nx;
	logic [IW-1:0] slot_nx;
	logic          fresh_nx;
	logic          rej_nx;
	logic [1:0]    rej_st_nx;

	logic [31:0]   n_serial, n_object, r_object;
	logic [RB-1:0] n_refc;
	logic [3:0]    n_flags;
	mod_info_t     info;

	ght_modify #(.REFCOUNT_BITS(RB)) u_modify (
		.kind       (kind_q),
		.fresh      (fresh_q),
		.stk_full   (fsc_q >= CW'(SLOTS)),
		.obj_in     (obj_q),
		.exp_serial (exp_q),
		.old_serial (ent_rd_q[EW-1 -: 32]),
		.old_object (ent_rd_q[EW-33 -: 32]),
		.old_refc   (ent_rd_q[RB+3:4]),
		.old_flags  (ent_rd_q[3:0]),
		.new_serial (n_serial),
		.new_object (n_object),
		.new_refc   (n_refc),
		.new_flags  (n_flags),
		.res_object (r_object),
		.info       (info)
	);

	assign in_ready = (st_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign fire     = (st_q == S_MOD) && (!out_valid_q || out_ready);
	assign take     = (kind == K_RESERVE) || (kind == K_ALLOC);
	assign idx_bad  = (kind > K_READ) || (slot_index == '0) ||
		({1'b0, slot_index} >= (IW+1)'(SLOTS));

	always_comb begin
		ent_re = 1'b0;
		ent_ra = slot_index;
		stk_re = accept && take && (fsc_q != '0);
		if (st_q == S_POP) begin
			ent_re = 1'b1;
			ent_ra = stk_rd_q;
		end else if (accept && take && fsc_q == '0 && bump_q < CW'(SLOTS)) begin
			ent_re = 1'b1;
			ent_ra = bump_q[IW-1:0];
		end else if (accept && !take && !idx_bad) begin
			ent_re = 1'b1;
		end
		ent_we = (st_q == S_CLR) || (fire && !rej_q);
		ent_wa = (st_q == S_CLR) ? clr_q : slot_q;
		ent_wd = (st_q == S_CLR) ? '0 : {n_serial, n_object, n_refc, n_flags};
		stk_we = fire && !rej_q && info.push;
		live_nx = live_q;
		if (fire && !rej_q) begin
			if (info.live_inc)
				live_nx = live_q + 1'b1;
			else if (info.live_dec && live_q != '0)
				live_nx = live_q - 1'b1;
		end
		slot_nx   = slot_index;
		fresh_nx  = 1'b0;
		rej_nx    = 1'b0;
		rej_st_nx = ST_REJECT;
		if (take) begin
			if (fsc_q == '0) begin
				if (bump_q < CW'(SLOTS)) begin
					slot_nx  = bump_q[IW-1:0];
					fresh_nx = 1'b1;
				end else begin
					slot_nx   = '0;
					rej_nx    = 1'b1;
					rej_st_nx = ST_FULL;
				end
			end
		end else if (idx_bad) begin
			rej_nx = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_wa] <= ent_wd;
		if (ent_re) ent_rd_q <= ent_mem[ent_ra];
		if (stk_we) stk_mem[fsc_q[IW-1:0]] <= slot_q;
		if (stk_re) stk_rd_q <= stk_mem[IW'(fsc_q - 1'b1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_CLR;
			clr_q       <= '0;
			fsc_q       <= '0;
			bump_q      <= CW'(1);
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			live_q <= live_nx;
			if (fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(SLOTS-1))
						st_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						if (take && fsc_q != '0) begin
							fsc_q <= fsc_q - 1'b1;
							st_q  <= S_POP;
						end else begin
							if (take && bump_q < CW'(SLOTS))
								bump_q <= bump_q + 1'b1;
							st_q <= S_MOD;
						end
					end
				end
				S_POP: st_q <= S_MOD;
				S_MOD: begin
					if (fire) begin
						if (stk_we)
							fsc_q <= fsc_q + 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind;
			exp_q    <= expected_serial;
			obj_q    <= object_ref;
			fresh_q  <= fresh_nx;
			rej_q    <= rej_nx;
			rej_st_q <= rej_st_nx;
			slot_q   <= slot_nx;
		end else if (st_q == S_POP) begin
			slot_q <= stk_rd_q;
		end
		if (fire) begin
			slot_out_q <= slot_q;
			live_out_q <= live_nx;
			if (rej_q) begin
				status_q  <= rej_st_q;
				serial_q  <= '0;
				object_q  <= '0;
				refc_q    <= '0;
				flags_q   <= '0;
				changed_q <= 1'b0;
			end else begin
				status_q  <= info.status;
				serial_q  <= n_serial;
				object_q  <= r_object;
				refc_q    <= n_refc;
				flags_q   <= n_flags;
				changed_q <= info.changed;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign result_slot     = slot_out_q;
	assign result_serial   = serial_q;
	assign result_object   = object_q;
	assign result_refcount = refc_q;
	assign result_flags    = flags_q;
	assign changed         = changed_q;
	assign live_count      = live_out_q;

`ifndef SYNTHESIS
	a_fsc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fsc_q <= CW'(SLOTS)) else $error("free stack count beyond capacity");
	a_bump_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bump_q <= CW'(SLOTS) && bump_q != '0) else $error("bump pointer out of range");
	a_live_step: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> live_q == $past(live_q)) else $error("live count moved without write-back");
	a_pop_then_mod: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_POP |=> st_q == S_MOD) else $error("pop not followed by entry update");
`endif

endmodule
`default_nettype wire
